>>> hw/rtl/scrolling_text_row_buffer_macros.svh
// assertion macros used by the row buffer back end
`ifndef SCROLLING_TEXT_ROW_BUFFER_MACROS_SVH
`define SCROLLING_TEXT_ROW_BUFFER_MACROS_SVH

// same-cycle implication, checked out of reset
`define STB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("row buffer check failed");

// next-cycle implication, checked out of reset
`define STB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("row buffer check failed");

`endif

>>> hw/rtl/stb_pkg.sv
// shared types, codes and constants of the scrolling text row buffer
package stb_pkg;

    localparam int CHAR_W       = 8;
    localparam int IDX_W        = 10;
    localparam int DEF_NUM_ROWS = 16;
    localparam int DEF_NUM_COLS = 64;
    localparam int Q_DEPTH      = 2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

    typedef enum logic [1:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    // number of shifted copies of total that fit below lim, i.e. reduction steps
    function automatic int mod_steps(input int total, input int lim);
        int n;
        n = 0;
        for (int i = 0; i <= IDX_W; i++) begin
            if ((total << i) < lim) begin
                n = n + 1;
            end
        end
        return n;
    endfunction

endpackage

>>> hw/rtl/scrolling_text_row_buffer.sv
// top level of the scrolling text row buffer: front end, queue and back end
//
// character store for an LED wall text console, kept as a ring of NUM_ROWS rows
// input channel: i_valid / o_stall, a beat carries i_mode, i_char_code, i_cell_index
//   mode 0 appends i_char_code at the write position, mode 1 reads frame cell i_cell_index
// output channel: o_valid / i_stall, one beat of o_cell_char for each read, none for appends
// the front end classifies beats into a two-entry queue, so input is taken while the
//   back end works or while a read result waits on a stalled receiver
// back end work: plain char one write, newline a zero then spaces padded to row end,
//   read one step per shifted copy of the frame size below 1024 (none by default)
// one write port on the store sets the cost of newline padding: one cell per cycle
// reset: write position goes to cell zero and the whole frame reads as zero at once;
//   rows are tracked by a fill mark and a wrap flag, so no clearing pass runs
// a stalled result holds o_cell_char; the back end stops at the next read until taken
module scrolling_text_row_buffer #(
    parameter int NUM_ROWS = stb_pkg::DEF_NUM_ROWS,
    parameter int NUM_COLS = stb_pkg::DEF_NUM_COLS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_mode,
    input  logic [stb_pkg::CHAR_W-1:0] i_char_code,
    input  logic [stb_pkg::IDX_W-1:0]  i_cell_index,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [stb_pkg::CHAR_W-1:0] o_cell_char
);
    import stb_pkg::*;

    // front end to queue
    t_push push;
    logic  q_full;

    // queue to back end
    logic  q_valid;
    t_cmd  q_cmd;
    logic  q_pop;

    stb_front u_front (
        .i_valid      (i_valid),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_full       (q_full),
        .o_stall      (o_stall),
        .o_push       (push)
    );

    stb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_full  (q_full)
    );

    // store, write pointer and the frame read path
    stb_back #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (q_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_cell_char (o_cell_char)
    );

endmodule

>>> hw/rtl/stb_front.sv
// front end: accepts input beats and classifies them into queue commands
module stb_front (
    input  logic                        i_valid,
    input  logic                        i_mode,
    input  logic [stb_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [stb_pkg::IDX_W-1:0]   i_cell_index,
    input  logic                        i_full,
    output logic                        o_stall,
    output stb_pkg::t_push              o_push
);
    import stb_pkg::*;

    t_op op;

    always_comb begin
        if (i_mode) begin
            op = OP_READ;
        end else if (i_char_code == NEWLINE_CODE) begin
            op = OP_NEWLINE;
        end else begin
            op = OP_PUT;
        end
    end

    assign o_stall        = i_full;
    assign o_push.valid   = i_valid && !i_full;
    assign o_push.cmd.op  = op;
    assign o_push.cmd.ch  = i_char_code;
    assign o_push.cmd.idx = i_cell_index;

endmodule

>>> hw/rtl/stb_queue.sv
// short command queue between the front end and the back end
module stb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stb_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_valid,
    output stb_pkg::t_cmd  o_cmd,
    output logic           o_full
);
    import stb_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);

    t_cmd             r_data [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push.valid && (r_count != CNT_W'(Q_DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_data[r_wr_ptr] <= i_push.cmd;
                r_wr_ptr         <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_cmd   = r_data[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(Q_DEPTH));

endmodule

>>> hw/rtl/stb_back.sv
// back end: character store, write pointer, newline padding and frame reads
`include "scrolling_text_row_buffer_macros.svh"

module stb_back #(
    parameter int NUM_ROWS = stb_pkg::DEF_NUM_ROWS,
    parameter int NUM_COLS = stb_pkg::DEF_NUM_COLS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  stb_pkg::t_cmd              i_q_cmd,
    output logic                       o_pop,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [stb_pkg::CHAR_W-1:0] o_cell_char
);
    import stb_pkg::*;

    localparam int TOTAL     = NUM_ROWS * NUM_COLS;
    localparam int ADDR_W    = $clog2(TOTAL);
    localparam int CNT_W     = $clog2(TOTAL + 1);
    localparam int COL_W     = $clog2(NUM_COLS);
    localparam int SUM_W     = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
    localparam int MOD_STEPS = mod_steps(TOTAL, 1 << IDX_W);
    localparam int STEP_W    = $clog2(MOD_STEPS + 2);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(NUM_COLS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_MOD,
        S_ADDR,
        S_READ
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_base;
    logic [COL_W-1:0]  r_col;
    logic              r_wrapped;
    logic [CHAR_W-1:0] r_byte;
    logic              r_pad;
    logic [IDX_W-1:0]  r_idx;
    logic [STEP_W-1:0] r_step;
    logic              r_zero;
    logic [CHAR_W-1:0] r_rd_data;
    logic [CHAR_W-1:0] r_mem [TOTAL];

    logic [CNT_W-1:0]  cur_cell;
    logic [CNT_W-1:0]  row_end;
    logic [CNT_W-1:0]  start;
    logic [CNT_W-1:0]  entered_end;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  frame_cell;
    logic              rd_zero;
    logic [STEP_W-1:0] mod_k;
    logic [IDX_W-1:0]  mod_sub;

    assign cur_cell = r_base + CNT_W'(r_col);
    assign row_end  = r_base + CNT_W'(NUM_COLS);
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;

    // rotated frame address and zero mask for rows not yet entered and the unwritten tail of the current row
    always_comb begin
        start       = (row_end == CNT_W'(TOTAL)) ? '0 : row_end;
        sum         = SUM_W'(start) + SUM_W'(r_idx);
        frame_cell  = (sum >= SUM_W'(TOTAL)) ? sum - SUM_W'(TOTAL) : sum;
        entered_end = (r_col != '0) ? row_end : r_base;
        rd_zero     = !(r_wrapped || (frame_cell < SUM_W'(entered_end)))
                    || ((r_col != '0) && (frame_cell >= SUM_W'(cur_cell))
                        && (frame_cell < SUM_W'(row_end)));
    end

    // one restoring step of the index reduction
    always_comb begin
        mod_k   = r_step - 1'b1;
        mod_sub = IDX_W'(TOTAL) << mod_k;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_mem[cur_cell[ADDR_W-1:0]] <= r_byte;
        end
        if (r_state == S_ADDR) begin
            r_rd_data <= r_mem[frame_cell[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_base    <= '0;
            r_col     <= '0;
            r_wrapped <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            // a taken result drops unless a new one replaces it below
            if (o_valid && !i_stall && (r_state != S_READ)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_idx  <= i_q_cmd.idx;
                        r_step <= STEP_W'(MOD_STEPS);
                        unique case (i_q_cmd.op)
                            OP_PUT: begin
                                r_byte  <= i_q_cmd.ch;
                                r_pad   <= 1'b0;
                                r_state <= S_WRITE;
                            end
                            OP_NEWLINE: begin
                                r_byte  <= '0;
                                r_pad   <= 1'b1;
                                r_state <= S_WRITE;
                            end
                            OP_READ: begin
                                r_state <= (MOD_STEPS == 0) ? S_ADDR : S_MOD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_WRITE: begin
                    if (r_col == COL_LAST) begin
                        r_col <= '0;
                        if (row_end == CNT_W'(TOTAL)) begin
                            r_base    <= '0;
                            r_wrapped <= 1'b1;
                        end else begin
                            r_base <= row_end;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    // newline pads spaces up to the end of the row
                    if (r_pad && (r_col != COL_LAST)) begin
                        r_byte <= SPACE_CODE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MOD: begin
                    if (r_idx >= mod_sub) begin
                        r_idx <= r_idx - mod_sub;
                    end
                    r_step <= r_step - 1'b1;
                    if (r_step == STEP_W'(1)) begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_zero  <= rd_zero;
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (!o_valid || !i_stall) begin
                        o_valid     <= 1'b1;
                        o_cell_char <= r_zero ? '0 : r_rd_data;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `STB_ASSERT_NEXT(a_col_wrap, i_clk, i_rst_n, r_state == S_WRITE && r_col == COL_LAST, r_col == '0)
    `STB_ASSERT_NEXT(a_read_out, i_clk, i_rst_n, r_state == S_READ && !(o_valid && i_stall), o_valid)
    `STB_ASSERT_IMPLY(a_wrap_origin, i_clk, i_rst_n, $rose(r_wrapped), r_base == '0 && r_col == '0)

endmodule

>>> test/scrolling_text_row_buffer_tb.sv
// testbench for the scrolling text row buffer: directed and random text checked against a shadow store
`timescale 1ns / 100ps

module scrolling_text_row_buffer_tb;
    import stb_pkg::*;

    localparam int ROWS  = DEF_NUM_ROWS;
    localparam int COLS  = DEF_NUM_COLS;
    localparam int CELLS = ROWS * COLS;

    // beat kinds on i_mode
    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off in the pressure test
    localparam int IDLE_LIMIT   = 3000;  // cycles with no beat on either side before giving up
    localparam int DRAIN_CYCLES = 150;   // covers a full row of newline padding and more
    localparam int RANDOM_BEATS = 1450;
    localparam int MAX_REPORTS  = 10;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              i_mode       = MODE_APPEND;
    logic [CHAR_W-1:0] i_char_code  = '0;
    logic [IDX_W-1:0]  i_cell_index = '0;
    logic              i_stall      = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [CHAR_W-1:0] o_cell_char;

    // shadow of the text console: char store and next write cell
    logic [CHAR_W-1:0] shadow_store [CELLS];
    int                write_pos;

    // chars the block owes us, oldest first
    logic [CHAR_W-1:0] pending_chars [$];

    int   mismatches  = 0;
    int   idle_cycles = 0;
    int   beats_sent  = 0;
    int   stall_left  = 0;
    int   stall_roll;
    bit   calm        = 1'b0;   // no random idling on either side while set
    bit   hold_req    = 1'b0;   // asks the receiver for one long hold-off

    scrolling_text_row_buffer #(
        .NUM_ROWS(ROWS),
        .NUM_COLS(COLS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_cell_index(i_cell_index),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cell_char (o_cell_char)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- shadow model

    // write one byte at the write position; entering a row wipes it first
    function automatic void store_byte(input logic [CHAR_W-1:0] b);
        if (write_pos % COLS == 0) begin
            for (int c = 0; c < COLS; c++) begin
                shadow_store[write_pos + c] = '0;
            end
        end
        shadow_store[write_pos] = b;
        write_pos = (write_pos + 1) % CELLS;
    endfunction

    // newline leaves a zero in its own cell and pads spaces to the end of the row
    function automatic void append_char(input logic [CHAR_W-1:0] ch);
        if (ch == NEWLINE_CODE) begin
            store_byte('0);
            while (write_pos % COLS != 0) begin
                store_byte(SPACE_CODE);
            end
        end else begin
            store_byte(ch);
        end
    endfunction

    // frame starts at the row after the one holding the write position
    function automatic logic [CHAR_W-1:0] frame_char(input logic [IDX_W-1:0] idx);
        int first_cell;
        first_cell = write_pos - (write_pos % COLS) + COLS;
        return shadow_store[(first_cell + (int'(idx) % CELLS)) % CELLS];
    endfunction

    // ---------------------------------------------------------------- receiver

    // receiver stall: the pressure hold-off first, then random gaps unless calm
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70) begin
                i_stall <= 1'b0;
            end else begin
                // mostly short holds, now and then a long one
                if (stall_roll < 92) begin
                    stall_left = $urandom_range(0, 2);
                end else if (stall_roll < 99) begin
                    stall_left = $urandom_range(3, 11);
                end else begin
                    stall_left = $urandom_range(29, 59);
                end
                i_stall <= 1'b1;
            end
        end
    end

    // result checker: every read beat out is matched against the oldest pending char
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_chars.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected result beat: cell_char %0d", o_cell_char);
                end
                mismatches++;
            end else if (o_cell_char !== pending_chars[0]) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("cell_char mismatch: expected %0d actual %0d",
                             pending_chars[0], o_cell_char);
                end
                mismatches++;
                void'(pending_chars.pop_front());
            end else begin
                void'(pending_chars.pop_front());
            end
        end
    end

    // watchdog: any beat on either side resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("scrolling_text_row_buffer_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sender

    // offer one beat after a random gap, wait until taken, then update the shadow
    task automatic send_beat(input logic mode, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx);
        int gap;
        int roll;
        gap  = 0;
        roll = $urandom_range(0, 99);
        if (!calm) begin
            if (roll >= 97) begin
                gap = $urandom_range(20, 60);
            end else if (roll >= 88) begin
                gap = $urandom_range(4, 10);
            end else if (roll >= 60) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_char_code  <= ch;
        i_cell_index <= idx;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        beats_sent++;
        if (mode == MODE_READ) begin
            pending_chars.push_back(frame_char(idx));
        end else begin
            append_char(ch);
        end
    endtask

    // the unused field carries random bits so ignoring it is exercised
    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_beat(MODE_APPEND, ch, IDX_W'($urandom));
    endtask

    task automatic read_cell(input logic [IDX_W-1:0] idx);
        send_beat(MODE_READ, CHAR_W'($urandom), idx);
    endtask

    // ---------------------------------------------------------------- tests

    // whole frame is zero straight out of reset
    task automatic test_reset_state();
        send_beat(MODE_READ, 8'h00, '0);
        send_beat(MODE_READ, 8'hFF, '1);
        read_cell(10'h155);
        read_cell(10'h2AA);
    endtask

    // byte extremes, ignored fields at both extremes, newline mid row
    task automatic test_directed();
        send_beat(MODE_APPEND, 8'h00, '0);
        send_beat(MODE_APPEND, 8'hFF, '1);
        put_char(8'h55);
        put_char(8'hAA);
        put_char(SPACE_CODE);
        read_cell(IDX_W'(CELLS - COLS));       // oldest column of the row being written
        read_cell(IDX_W'(CELLS - COLS + 4));
        read_cell(IDX_W'(CELLS - 1));
        put_char(NEWLINE_CODE);                // pads the rest of the row
        read_cell(IDX_W'(CELLS - COLS + 5));
        read_cell(IDX_W'(CELLS - COLS + 6));
        read_cell(IDX_W'(CELLS - 1));
        put_char(8'h01);
        put_char(8'h80);
        put_char(8'h7F);
        read_cell(IDX_W'(CELLS - 2 * COLS + 2));
        read_cell(IDX_W'(CELLS - COLS));
        read_cell(IDX_W'(CELLS - COLS + 2));
        read_cell('0);
    endtask

    // newline landing in the last column: no padding, next char starts a new row
    task automatic test_last_column_newline();
        if (write_pos % COLS != 0) begin
            put_char(NEWLINE_CODE);
        end
        for (int c = 0; c < COLS - 1; c++) begin
            put_char(CHAR_W'($urandom_range(33, 126)));
        end
        put_char(NEWLINE_CODE);
        read_cell(IDX_W'(CELLS - COLS - 1));
        read_cell(IDX_W'(CELLS - COLS - 2));
        put_char(8'h5A);
        read_cell(IDX_W'(CELLS - 2 * COLS - 1));
        read_cell(IDX_W'(CELLS - COLS));
        read_cell(IDX_W'(CELLS - COLS + 1));
    endtask

    // run the write position round the ring so row zero is cleared again
    task automatic test_wrap();
        for (int r = 0; r <= ROWS; r++) begin
            put_char(CHAR_W'($urandom));
            put_char(NEWLINE_CODE);
        end
        // fill a row to its last cell with chars so a row ends by plain writes too
        for (int c = 0; c < COLS + 3; c++) begin
            put_char(CHAR_W'($urandom_range(33, 126)));
        end
        read_cell('0);
        read_cell(IDX_W'(CELLS - 1));
        read_cell(IDX_W'(CELLS - COLS));
        read_cell(IDX_W'($urandom));
    endtask

    // receiver holds off for a long stretch while beats keep coming back to back
    task automatic test_backpressure();
        calm     = 1'b1;
        hold_req = 1'b1;
        for (int n = 0; n < 48; n++) begin
            case ($urandom_range(0, 5))
                0: put_char(NEWLINE_CODE);
                1, 2: put_char(CHAR_W'($urandom));
                default: read_cell(IDX_W'($urandom));
            endcase
        end
        calm = 1'b0;
    endtask

    // lines of random text with reads sprinkled in, plus some raw noise
    task automatic test_random_text();
        int line_len;
        int stop_at;
        stop_at = beats_sent + RANDOM_BEATS;
        while (beats_sent < stop_at) begin
            // now and then a line with no idling at all
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0) begin
                // noise: any byte, any read, newline included by chance
                for (int n = $urandom_range(1, 8); n > 0; n--) begin
                    if ($urandom_range(0, 1) == 0) begin
                        put_char(CHAR_W'($urandom));
                    end else begin
                        read_cell(IDX_W'($urandom));
                    end
                end
            end else begin
                // mostly short lines, some that run past the row end
                line_len = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 140)
                                                       : $urandom_range(0, 30);
                for (int c = 0; c < line_len; c++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        put_char(CHAR_W'($urandom));
                    end else begin
                        put_char(CHAR_W'($urandom_range(32, 126)));
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        read_cell(IDX_W'($urandom));
                    end
                end
                if ($urandom_range(0, 4) != 0) begin
                    put_char(NEWLINE_CODE);
                end
                for (int n = $urandom_range(1, 4); n > 0; n--) begin
                    read_cell(IDX_W'($urandom));
                end
            end
        end
        calm = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            shadow_store[i] = '0;
        end
        write_pos = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed();
        test_last_column_newline();
        test_wrap();
        test_backpressure();
        test_random_text();

        i_valid <= 1'b0;
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("scrolling_text_row_buffer_tb OK");
        end else begin
            $display("scrolling_text_row_buffer_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/stb_pkg.sv
hw/rtl/stb_front.sv
hw/rtl/stb_queue.sv
hw/rtl/stb_back.sv
hw/rtl/scrolling_text_row_buffer.sv
test/scrolling_text_row_buffer_tb.sv
